FILE: rtl/wiac_pkg.sv
`default_nettype none

package wiac_pkg;

  localparam int DATA_BITS     = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int FUNC_BITS     = 3;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_ADC    = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_SUB    = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_SBB    = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_MUL    = 3'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_DIV64  = 3'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_DIV128 = 3'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_BITLEN = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } wiac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iter_req;
  } wiac_sts_t;

endpackage

`default_nettype wire

FILE: rtl/wide_integer_alu_with_carry.sv
`default_nettype none

// channel   | valid      | ready      | payload
// ----------+------------+------------+-------------------------------------------------
// request   | in_valid   | in_ready   | in_func, in_operand_a, in_operand_b, in_operand_c
// result    | out_valid  | out_ready  | out_word_first, out_word_second, out_carry_out,
//           |            |            | out_ok
//
// Add/sub and refused divides: accepted, then the done state captures the result.
// Multiply, divide and bit length run WORD_BITS steps on the shared hi/lo shift
// registers, one bit a step, before the done state captures the result.
// Reset clears the carry flag, the controller and the result valid.
// A held result does not stop a new request; a finished one waits while the result
// register is still full.

module wide_integer_alu_with_carry
  import wiac_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_BITS-1:0] in_func,
  input  wire logic [DATA_BITS-1:0] in_operand_a,
  input  wire logic [DATA_BITS-1:0] in_operand_b,
  input  wire logic [DATA_BITS-1:0] in_operand_c,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_BITS-1:0]      out_word_first,
  output logic [DATA_BITS-1:0]      out_word_second,
  output logic                      out_carry_out,
  output logic                      out_ok
);

  wiac_cmd_t cmd;
  wiac_sts_t sts;

  wiac_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wiac_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_operand_c    (in_operand_c),
    .out_word_first  (out_word_first),
    .out_word_second (out_word_second),
    .out_carry_out   (out_carry_out),
    .out_ok          (out_ok)
  );

  a_load_step_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step issued together");

  a_capture_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");

  a_busy_not_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.capture) |-> !in_ready)
    else $error("request taken while a result is in progress");

  a_capture_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: rtl/wiac_ctrl.sv
`default_nettype none

module wiac_ctrl
  import wiac_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire wiac_sts_t sts,
  output wiac_cmd_t      cmd
);

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    // drop the held result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.iter_req ? ST_BUSY : ST_DONE;
        end
      end
      ST_BUSY: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wiac_dp.sv
`default_nettype none

module wiac_dp
  import wiac_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wiac_cmd_t            cmd,
  output wiac_sts_t                 sts,
  input  wire logic [FUNC_BITS-1:0] in_func,
  input  wire logic [DATA_BITS-1:0] in_operand_a,
  input  wire logic [DATA_BITS-1:0] in_operand_b,
  input  wire logic [DATA_BITS-1:0] in_operand_c,
  output logic [DATA_BITS-1:0]      out_word_first,
  output logic [DATA_BITS-1:0]      out_word_second,
  output logic                      out_carry_out,
  output logic                      out_ok
);

  localparam int W = WORD_BITS;

  logic [W-1:0]         a, b, c;
  logic                 cin;
  logic [W:0]           addsub;
  logic                 div64_go, div128_go;

  logic [W-1:0]         hi_r, hi_nxt;
  logic [W-1:0]         lo_r, lo_nxt;
  logic [W-1:0]         d_r, d_nxt;
  logic [FUNC_BITS-1:0] op_r, op_nxt;
  logic                 ok_r, ok_nxt;
  logic                 carry_r, carry_nxt;

  logic [W:0]           mul_sum;
  logic [W:0]           div_diff;
  logic                 qbit;

  logic [W-1:0]         first, second;
  logic [DATA_BITS-1:0] out_word_first_r, out_word_second_r;
  logic                 out_carry_out_r, out_ok_r;

  assign a = in_operand_a[W-1:0];
  assign b = in_operand_b[W-1:0];
  assign c = in_operand_c[W-1:0];

  assign cin = ((in_func == FUNC_ADC) || (in_func == FUNC_SBB)) && carry_r;

  assign div64_go  = (b != '0);
  assign div128_go = (c > a);

  assign sts.iter_req = (in_func == FUNC_MUL) || (in_func == FUNC_BITLEN)
                      || ((in_func == FUNC_DIV64) && div64_go)
                      || ((in_func == FUNC_DIV128) && div128_go);

  always_comb begin
    addsub = '0;
    if ((in_func == FUNC_SUB) || (in_func == FUNC_SBB)) begin
      addsub = {1'b0, a} - {1'b0, b} - {{W{1'b0}}, cin};
    end else begin
      addsub = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
    end
  end

  // shift-add multiply step and restoring divide step
  assign mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, d_r} : '0);
  assign div_diff = {hi_r, lo_r[W-1]} - {1'b0, d_r};
  assign qbit     = ~div_diff[W];

  always_comb begin
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    d_nxt     = d_r;
    op_nxt    = op_r;
    ok_nxt    = ok_r;
    carry_nxt = carry_r;
    if (cmd.load) begin
      op_nxt = in_func;
      ok_nxt = 1'b1;
      hi_nxt = '0;
      lo_nxt = '0;
      d_nxt  = d_r;
      case (in_func)
        FUNC_ADD, FUNC_ADC, FUNC_SUB, FUNC_SBB: begin
          hi_nxt    = addsub[W-1:0];
          carry_nxt = addsub[W];
        end
        FUNC_MUL: begin
          lo_nxt = b;
          d_nxt  = a;
        end
        FUNC_DIV64: begin
          if (div64_go) begin
            lo_nxt = a;
            d_nxt  = b;
          end else begin
            lo_nxt = a;
            hi_nxt = b;
            ok_nxt = 1'b0;
          end
        end
        FUNC_DIV128: begin
          if (div128_go) begin
            hi_nxt = a;
            lo_nxt = b;
            d_nxt  = c;
          end else begin
            lo_nxt = a;
            hi_nxt = b;
            ok_nxt = 1'b0;
          end
        end
        default: begin
          lo_nxt = a;
        end
      endcase
    end else if (cmd.step) begin
      case (op_r)
        FUNC_MUL: begin
          hi_nxt = mul_sum[W:1];
          lo_nxt = {mul_sum[0], lo_r[W-1:1]};
        end
        FUNC_DIV64, FUNC_DIV128: begin
          hi_nxt = qbit ? div_diff[W-1:0] : {hi_r[W-2:0], lo_r[W-1]};
          lo_nxt = {lo_r[W-2:0], qbit};
        end
        FUNC_BITLEN: begin
          // count shifts until the word runs out of ones
          if (lo_r != '0) begin
            hi_nxt = hi_r + 1'b1;
            lo_nxt = lo_r >> 1;
          end
        end
        default: begin
          hi_nxt = hi_r;
        end
      endcase
    end
  end

  // divide keeps the quotient in lo and the remainder in hi
  always_comb begin
    if (op_r inside {FUNC_DIV64, FUNC_DIV128}) begin
      first  = lo_r;
      second = hi_r;
    end else begin
      first  = hi_r;
      second = lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    d_r  <= d_nxt;
    op_r <= op_nxt;
    ok_r <= ok_nxt;
    if (cmd.capture) begin
      out_word_first_r  <= DATA_BITS'(first);
      out_word_second_r <= DATA_BITS'(second);
      out_carry_out_r   <= carry_r;
      out_ok_r          <= ok_r;
    end
  end

  assign out_word_first  = out_word_first_r;
  assign out_word_second = out_word_second_r;
  assign out_carry_out   = out_carry_out_r;
  assign out_ok          = out_ok_r;

endmodule

`default_nettype wire
